FILE: src/first_fit_region_allocator_assert.svh
// ---------------------------------------------------------------------------
// First-fit region allocator: assertion macros
// Clocked implication checks shared by the controller and the datapath.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFRA_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ffra: same-cycle check failed");

// next-cycle implication
`define FFRA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ffra: next-cycle check failed");

`endif

FILE: src/ffra_pkg.sv
// ---------------------------------------------------------------------------
// ffra_pkg
// Types, codes and constants of the first-fit region allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    localparam int ADDR_BITS      = 31;
    localparam int LINK_BITS      = 4;
    localparam int SLOT_COUNT_DEF = 10;

    localparam logic [LINK_BITS-1:0] UNUSED_CODE = 4'hF;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
        logic finish;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic hit;
    } t_stat;

endpackage

`default_nettype wire

FILE: src/ffra_ctrl.sv
// ---------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: accepts a request, steps the list walk, commits and holds
// the result transfer until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "first_fit_region_allocator_assert.svh"

module ffra_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire ffra_pkg::t_stat i_stat,
    output ffra_pkg::t_cmd      o_cmd
);
    import ffra_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.done || i_stat.hit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_COMMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_COMMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `FFRA_ASSERT_NEXT(a_accept_walks, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == ST_WALK)
    `FFRA_ASSERT_NOW(a_commit_slot_free, i_clk, i_rst_n, o_cmd.commit, !r_out_valid || !i_out_stall)
    `FFRA_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, o_cmd.commit, o_out_valid && !o_in_stall)

endmodule

`default_nettype wire

FILE: src/ffra_dpath.sv
// ---------------------------------------------------------------------------
// ffra_dpath
// Slot table, list walk registers, free-slot search and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "first_fit_region_allocator_assert.svh"

module ffra_dpath #(
    parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ffra_pkg::t_cmd                i_cmd,
    output ffra_pkg::t_stat                    o_stat,
    input  wire logic [ffra_pkg::ADDR_BITS-1:0] i_heap_base,
    input  wire logic                          i_mode,
    input  wire logic [ffra_pkg::ADDR_BITS-1:0] i_alloc_length,
    input  wire logic [ffra_pkg::ADDR_BITS-1:0] i_free_address,
    output logic [1:0]                         o_status,
    output logic [ffra_pkg::ADDR_BITS-1:0]     o_region_start,
    output logic [ffra_pkg::ADDR_BITS-1:0]     o_region_length
);
    import ffra_pkg::*;

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int STEP_W = $clog2(SLOT_COUNT + 1);

    logic [LINK_BITS-1:0] r_link   [SLOT_COUNT];
    logic [ADDR_BITS-1:0] r_start  [SLOT_COUNT];
    logic [ADDR_BITS-1:0] r_length [SLOT_COUNT];

    logic                 r_mode;
    logic [ADDR_BITS-1:0] r_len;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_cand;
    logic [IDX_W-1:0]     r_pre;
    logic [IDX_W-1:0]     r_cur;
    logic [STEP_W-1:0]    r_steps;
    logic                 r_found;

    logic [1:0]           r_status;
    logic [ADDR_BITS-1:0] r_res_start;
    logic [ADDR_BITS-1:0] r_res_length;

    logic [ADDR_BITS-1:0] cur_start;
    logic [ADDR_BITS-1:0] cur_len;
    logic [ADDR_BITS-1:0] end_addr;
    logic [ADDR_BITS:0]   fit_sum;
    logic                 fit;
    logic                 walk_done;
    logic                 limit_hit;
    logic [IDX_W-1:0]     next_idx;
    logic [IDX_W-1:0]     head_idx;
    logic [IDX_W-1:0]     cur_final;
    logic [IDX_W-1:0]     free_idx;
    logic                 free_found;
    logic                 alloc_commit;

    // out-of-range link ends the walk
    function automatic logic [IDX_W-1:0] next_of(input logic [LINK_BITS-1:0] link);
        if (link < LINK_BITS'(SLOT_COUNT)) begin
            return link[IDX_W-1:0];
        end
        return '0;
    endfunction

    always_comb begin
        cur_start = r_start[r_cur];
        cur_len   = r_length[r_cur];
        end_addr  = cur_start + cur_len;
        fit_sum   = {1'b0, r_cand} + {1'b0, r_len};
        fit       = fit_sum < {1'b0, cur_start};
        next_idx  = next_of(r_link[r_cur]);
        head_idx  = next_of(r_link[0]);
        limit_hit = (r_steps >= STEP_W'(SLOT_COUNT));
        walk_done = (r_cur == '0) || limit_hit;
        o_stat.done = walk_done;
        o_stat.hit  = !walk_done && ((r_mode == MODE_ALLOC) ? fit : (cur_start == r_addr));
        cur_final   = limit_hit ? '0 : r_cur;
    end

    // lowest unused slot, head excluded
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int k = SLOT_COUNT - 1; k >= 1; k--) begin
            if (r_link[k] == UNUSED_CODE) begin
                free_idx   = IDX_W'(k);
                free_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k < SLOT_COUNT; k++) begin
                r_link[k] <= UNUSED_CODE;
            end
            r_link[0] <= '0;
        end else if (i_cmd.commit) begin
            if (r_mode == MODE_ALLOC) begin
                if (free_found) begin
                    r_link[free_idx] <= LINK_BITS'(cur_final);
                    r_link[r_pre]    <= LINK_BITS'(free_idx);
                end
            end else if (r_found) begin
                r_link[r_pre] <= LINK_BITS'(next_idx);
                r_link[r_cur] <= UNUSED_CODE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_mode == MODE_ALLOC) && free_found) begin
            r_start[free_idx]  <= r_cand;
            r_length[free_idx] <= r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_found <= 1'b0;
            r_pre   <= '0;
            r_cur   <= '0;
        end else if (i_cmd.load) begin
            r_steps <= '0;
            r_found <= 1'b0;
            r_pre   <= '0;
            r_cur   <= head_idx;
        end else if (i_cmd.advance) begin
            r_steps <= r_steps + STEP_W'(1);
            r_pre   <= r_cur;
            r_cur   <= next_idx;
        end else if (i_cmd.finish) begin
            r_found <= o_stat.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_len  <= i_alloc_length;
            r_addr <= i_free_address;
            r_cand <= i_heap_base;
        end else if (i_cmd.advance && (r_mode == MODE_ALLOC)) begin
            r_cand <= end_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_mode == MODE_ALLOC) begin
                if (free_found) begin
                    r_status     <= STATUS_OK;
                    r_res_start  <= r_cand;
                    r_res_length <= r_len;
                end else begin
                    r_status     <= STATUS_NO_SLOT;
                    r_res_start  <= '0;
                    r_res_length <= '0;
                end
            end else if (r_found) begin
                r_status     <= STATUS_OK;
                r_res_start  <= cur_start;
                r_res_length <= cur_len;
            end else begin
                r_status     <= STATUS_NOT_FOUND;
                r_res_start  <= '0;
                r_res_length <= '0;
            end
        end
    end

    assign alloc_commit    = i_cmd.commit && (r_mode == MODE_ALLOC) && free_found;
    assign o_status        = r_status;
    assign o_region_start  = r_res_start;
    assign o_region_length = r_res_length;

    `FFRA_ASSERT_NOW(a_walk_bounded, i_clk, i_rst_n, 1'b1, r_steps <= STEP_W'(SLOT_COUNT))
    `FFRA_ASSERT_NOW(a_head_in_use, i_clk, i_rst_n, 1'b1, r_link[0] != UNUSED_CODE)
    `FFRA_ASSERT_NOW(a_link_point_used, i_clk, i_rst_n, alloc_commit, r_pre != free_idx)

endmodule

`default_nettype wire

FILE: src/first_fit_region_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_region_allocator
// Address-ordered list of allocated regions in a slot table; first-fit
// allocate and free-by-start requests, one result per request.
// ---------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  request  | i_in_valid / o_in_stall     | i_mode, i_alloc_length, i_free_address
//  result   | o_out_valid / i_out_stall   | o_status, o_region_start, o_region_length
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata (heap_base at 0x0)
//
//  A request is loaded in ST_IDLE, walks the list in the slot table entry by entry
//  in ST_WALK, then commits in ST_COMMIT once the result register is free.
//  Only one request is in flight; the next is taken once the commit is done.
//  The result register holds a finished transfer while the next request walks.
//  Synchronous active-low reset empties the list and clears heap_base.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator #(
    parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_mode,
    input  wire logic [ffra_pkg::ADDR_BITS-1:0] i_alloc_length,
    input  wire logic [ffra_pkg::ADDR_BITS-1:0] i_free_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic [ffra_pkg::ADDR_BITS-1:0]     o_region_start,
    output logic [ffra_pkg::ADDR_BITS-1:0]     o_region_length,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import ffra_pkg::*;

    logic [ADDR_BITS-1:0] r_heap_base;
    t_cmd                 cmd;
    t_stat                stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_heap_base <= pwdata[ADDR_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_heap_base);

    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ffra_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_heap_base     (r_heap_base),
        .i_mode          (i_mode),
        .i_alloc_length  (i_alloc_length),
        .i_free_address  (i_free_address),
        .o_status        (o_status),
        .o_region_start  (o_region_start),
        .o_region_length (o_region_length)
    );

endmodule

`default_nettype wire

FILE: verif/first_fit_region_allocator_test.sv
// ---------------------------------------------------------------------------
// first_fit_region_allocator_test
// Self-checking bench for the first-fit region allocator. A short table of
// directed requests covers the empty list, zero and maximum lengths, the
// full table, equal starts and unknown frees. It is followed by random
// phases, each under its own heap base set over the APB port. A shadow
// slot-table predicts every result, and the results are checked in order
// while both channels idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator_test;

    import ffra_pkg::*;

    localparam int SLOTS         = SLOT_COUNT_DEF;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = SLOTS + 8;
    localparam int PHASE_ITEMS   = 136;
    localparam int PHASES        = 5;

    localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;
    localparam logic [2:0] HEAP_BASE_ADDR = 3'd0;
    localparam logic [2:0] UNMAPPED_ADDR  = 3'd4;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] length;
    } t_region_result;

    typedef struct {
        logic                 mode;
        logic [ADDR_BITS-1:0] len;
        logic [ADDR_BITS-1:0] addr;
        bit                   typed;
        logic [1:0]           status;
    } t_stim_row;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode         = MODE_ALLOC;
    logic [ADDR_BITS-1:0] i_alloc_length = '0;
    logic [ADDR_BITS-1:0] i_free_address = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [1:0]           o_status;
    logic [ADDR_BITS-1:0] o_region_start;
    logic [ADDR_BITS-1:0] o_region_length;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [2:0]           paddr          = '0;
    logic [31:0]          pwdata         = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // shadow slot table
    logic [LINK_BITS-1:0] link_q   [SLOTS];
    logic [ADDR_BITS-1:0] start_q  [SLOTS];
    logic [ADDR_BITS-1:0] length_q [SLOTS];
    logic [ADDR_BITS-1:0] heap_base_q;

    t_region_result pending_results[$];
    t_region_result want;
    t_stim_row      stim_rows[$];

    int errors       = 0;
    int n_requests   = 0;
    int n_results    = 0;
    int n_ok         = 0;
    int n_no_slot    = 0;
    int n_not_found  = 0;
    int n_cfg_writes = 0;
    int burst_left   = 5;
    int stall_left   = 0;
    int stall_mode   = 0;
    int idle_cycles  = 0;

    first_fit_region_allocator #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_alloc_length (i_alloc_length),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_region_start (o_region_start),
        .o_region_length(o_region_length),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [LINK_BITS-1:0] next_slot(input int k);
        return (link_q[k] < SLOTS) ? link_q[k] : '0;
    endfunction

    function automatic t_region_result predict_request(input logic m,
                                                       input logic [ADDR_BITS-1:0] len,
                                                       input logic [ADDR_BITS-1:0] addr);
        logic [LINK_BITS-1:0] prev;
        logic [LINK_BITS-1:0] cur;
        logic [ADDR_BITS-1:0] cand;
        t_region_result       res;
        int                   steps;
        bit                   done;
        prev  = '0;
        steps = 0;
        done  = 1'b0;
        cur   = next_slot(0);
        if (m == MODE_ALLOC) begin
            cand = heap_base_q;
            while (cur != 0 && steps < SLOTS && !done) begin
                // fit test is done without wrap
                if ({1'b0, cand} + {1'b0, len} < {1'b0, start_q[cur]}) begin
                    done = 1'b1;
                end else begin
                    cand  = start_q[cur] + length_q[cur];
                    prev  = cur;
                    cur   = next_slot(cur);
                    steps++;
                end
            end
            if (steps >= SLOTS) cur = '0;
            res  = '{STATUS_NO_SLOT, '0, '0};
            done = 1'b0;
            for (int k = 1; k < SLOTS; k++) begin
                if (!done && link_q[k] == UNUSED_CODE) begin
                    link_q[k]   = cur;
                    start_q[k]  = cand;
                    length_q[k] = len;
                    link_q[prev] = LINK_BITS'(k);
                    res  = '{STATUS_OK, cand, len};
                    done = 1'b1;
                end
            end
        end else begin
            res = '{STATUS_NOT_FOUND, '0, '0};
            while (cur != 0 && steps < SLOTS && !done) begin
                if (start_q[cur] == addr) begin
                    res          = '{STATUS_OK, start_q[cur], length_q[cur]};
                    link_q[prev] = next_slot(cur);
                    link_q[cur]  = UNUSED_CODE;
                    done         = 1'b1;
                end else begin
                    prev = cur;
                    cur  = next_slot(cur);
                    steps++;
                end
            end
        end
        return res;
    endfunction

    task automatic add_row(input logic m, input logic [ADDR_BITS-1:0] len,
                           input logic [ADDR_BITS-1:0] addr, input bit typed,
                           input logic [1:0] status);
        t_stim_row row;
        row = '{m, len, addr, typed, status};
        stim_rows.push_back(row);
    endtask

    task automatic send_request(input logic m, input logic [ADDR_BITS-1:0] len,
                                input logic [ADDR_BITS-1:0] addr, input bit typed,
                                input logic [1:0] typed_status, input bit last);
        t_region_result predicted;
        int             gap;
        i_in_valid     <= 1'b1;
        i_mode         <= m;
        i_alloc_length <= len;
        i_free_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        n_requests++;
        predicted = predict_request(m, len, addr);
        if (typed) predicted = '{typed_status, '0, '0};
        pending_results.push_back(predicted);
        if (last || burst_left == 0) i_in_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (a == HEAP_BASE_ADDR) heap_base_q = d[ADDR_BITS-1:0];
        n_cfg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= HEAP_BASE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[ADDR_BITS-1:0] !== heap_base_q) begin
            $error("heap_base: expected %h, got %h", heap_base_q, prdata[ADDR_BITS-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // result receiver: stall pattern changes character whenever its random hold count runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= stall_left[3];
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: status %0d start %h length %h",
                       o_status, o_region_start, o_region_length);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_region_start !== want.start) begin
                    $error("region_start: expected %h, got %h", want.start, o_region_start);
                    errors++;
                end
                if (o_region_length !== want.length) begin
                    $error("region_length: expected %h, got %h", want.length, o_region_length);
                    errors++;
                end
                case (want.status)
                    STATUS_OK:      n_ok++;
                    STATUS_NO_SLOT: n_no_slot++;
                    default:        n_not_found++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("FAIL first_fit_region_allocator");
        $finish;
    end

    initial begin
        logic                 m;
        logic [ADDR_BITS-1:0] len;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] live[$];
        int                   r;

        for (int k = 0; k < SLOTS; k++) begin
            link_q[k]   = UNUSED_CODE;
            start_q[k]  = '0;
            length_q[k] = '0;
        end
        link_q[0]   = '0;
        heap_base_q = '0;

        // heap base 0 after reset
        add_row(MODE_FREE,  '0,               '0,               1'b1, STATUS_NOT_FOUND);
        add_row(MODE_ALLOC, '0,               '0,               1'b1, STATUS_OK);
        add_row(MODE_ALLOC, ADDR_MAX,         '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'd16,           '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'd1,            '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'd100,          '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'd200,          '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, '0,               '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'd5,            '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'h4000_0000,    '0,               1'b0, STATUS_OK);
        // table is full now
        add_row(MODE_ALLOC, 31'd7,            '0,               1'b1, STATUS_NO_SLOT);
        add_row(MODE_ALLOC, ADDR_MAX,         ADDR_MAX,         1'b1, STATUS_NO_SLOT);
        // equal starts: first listed match goes first
        add_row(MODE_FREE,  '0,               '0,               1'b0, STATUS_OK);
        add_row(MODE_FREE,  '0,               '0,               1'b0, STATUS_OK);
        add_row(MODE_FREE,  ADDR_MAX,         ADDR_MAX,         1'b0, STATUS_OK);
        add_row(MODE_FREE,  '0,               31'h0001_2345,    1'b0, STATUS_OK);
        add_row(MODE_FREE,  ADDR_MAX,         ADDR_MAX,         1'b0, STATUS_OK);
        add_row(MODE_ALLOC, '0,               ADDR_MAX,         1'b0, STATUS_OK);
        add_row(MODE_FREE,  ADDR_MAX,         '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'd3,            '0,               1'b0, STATUS_OK);
        add_row(MODE_ALLOC, 31'h7FFF_FFFE,    '0,               1'b0, STATUS_OK);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            send_request(stim_rows[i].mode, stim_rows[i].len, stim_rows[i].addr,
                         stim_rows[i].typed, stim_rows[i].status,
                         i == stim_rows.size() - 1);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            while (pending_results.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (phase)
                0: begin
                    apb_write(HEAP_BASE_ADDR, 32'h7FFF_FFFF);
                end
                1: begin
                    apb_write(HEAP_BASE_ADDR, 32'h0000_0000);
                    apb_write(UNMAPPED_ADDR, $urandom());
                end
                2: begin
                    apb_write(HEAP_BASE_ADDR, $urandom());
                end
                3: begin
                    apb_write(HEAP_BASE_ADDR, 32'hFFFF_FF00);
                end
                default: begin
                    apb_write(HEAP_BASE_ADDR, $urandom_range(0, 4095));
                end
            endcase
            apb_read_check();

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                m    = 1'($urandom_range(0, 1));
                len  = ADDR_BITS'($urandom());
                addr = ADDR_BITS'($urandom());
                if (r >= 10) begin
                    live.delete();
                    for (int k = 1; k < SLOTS; k++) begin
                        if (link_q[k] != UNUSED_CODE) live.push_back(start_q[k]);
                    end
                    if (r < 50 || live.size() == 0) begin
                        m = MODE_ALLOC;
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5: len = ADDR_BITS'($urandom_range(0, 255));
                            6, 7:             len = ADDR_BITS'($urandom_range(0, 65535));
                            8:                len = ADDR_BITS'($urandom());
                            default:          len = $urandom_range(0, 1) ? ADDR_MAX : '0;
                        endcase
                    end else if (r < 90) begin
                        m    = MODE_FREE;
                        addr = live[$urandom_range(0, live.size() - 1)];
                    end else begin
                        m    = MODE_FREE;
                        addr = heap_base_q + ADDR_BITS'($urandom_range(0, 300));
                    end
                end
                send_request(m, len, addr, 1'b0, STATUS_OK, n == PHASE_ITEMS - 1);
            end
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests (%0d directed) and %0d results checked over %0d config writes",
                 n_requests, stim_rows.size(), n_results, n_cfg_writes);
        $display("outcomes: %0d success, %0d table full, %0d start not found",
                 n_ok, n_no_slot, n_not_found);
        if (errors == 0) begin
            $display("PASS first_fit_region_allocator");
        end else begin
            $display("FAIL first_fit_region_allocator");
        end
        $finish;
    end

endmodule

`default_nettype wire
